// ----- rtl/lrc_pkg.sv -----
// shared constants and character-class helpers for the lrc timestamp parser
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

   // result kinds
   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_STAMP = 1'b1;

   // field widths
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TIME_W = 23;
   localparam int unsigned IDX_W  = 4;

   // stamp layout: nine gathered bytes, tenth byte closes the stamp
   localparam int unsigned STAMP_LEN   = 10;
   localparam int unsigned STAMP_DEPTH = STAMP_LEN - 1;

   // byte codes
   localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_OPEN   = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE  = 8'h5D;
   localparam logic [BYTE_W-1:0] CHAR_COLON  = 8'h3A;

   // time weights in milliseconds
   localparam int unsigned MS_PER_MIN  = 60000;
   localparam int unsigned MS_PER_SEC  = 1000;
   localparam int unsigned MS_PER_DSEC = 100;
   localparam int unsigned MS_PER_CSEC = 10;

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   // printable, not letter or digit
   function automatic logic is_punct(input logic [BYTE_W-1:0] b);
      return ((b >= 8'd33)  && (b <= 8'd47))  ||
             ((b >= 8'd58)  && (b <= 8'd64))  ||
             ((b >= 8'd91)  && (b <= 8'd96))  ||
             ((b >= 8'd123) && (b <= 8'd126));
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lrc_lyric_timestamp_parser.sv -----
// top level of the lrc lyric timestamp parser
`timescale 1ns / 1ps
`default_nettype none

// Streams an lrc lyric file one byte per request. Each line must open with a
// ten byte stamp of the form [MM:ss.cc]; a good stamp yields a stamp result
// (kind 1) with the time in ms and the delay since the previous stamp, and
// the rest of that line comes out as character results (kind 0). A line with
// a bad stamp is dropped up to its line feed, carriage returns after the
// stamp are dropped, and a zero byte halts the parser until a request with
// restart set. A time earlier than the previous one gives delay 0 and sets
// backwards. The block takes one request per cycle while the result channel
// does not stall; each request is held in the input register and its result,
// if any, is loaded into the result register when the request moves on. The
// parser state (stamp bytes, index, line flags, last time) is updated in the
// same cycle that the result register is loaded.
module lrc_lyric_timestamp_parser (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [lrc_pkg::BYTE_W-1:0]        req_byte_in,
   input  wire                               req_restart,
   // result channel
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_kind,
   output logic [lrc_pkg::BYTE_W-1:0]        rsp_char_code,
   output logic [lrc_pkg::TIME_W-1:0]        rsp_time_ms,
   output logic [lrc_pkg::TIME_W-1:0]        rsp_delay_ms,
   output logic                              rsp_backwards
);
   import lrc_pkg::*;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_restart_ff;

   // parser state
   logic [BYTE_W-1:0] stamp_buf_ff [STAMP_DEPTH];
   logic [IDX_W-1:0]  stamp_idx_ff, stamp_idx_in;
   logic              reading_ff, reading_in;
   logic              show_ff, show_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic              stopped_ff, stopped_in;
   logic              buf_we;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0] rsp_char_ff, rsp_char_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic [TIME_W-1:0] rsp_delay_ff, rsp_delay_in;
   logic              rsp_back_ff, rsp_back_in;

   // the held request moves on when the result slot is free or being emptied
   logic advance;
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff    <= req_byte_in;
         in_restart_ff <= req_restart;
      end
   end

   // stamp decode from the gathered bytes plus the closing byte
   logic              stamp_ok;
   logic [3:0]        d_min_hi, d_min_lo, d_sec_hi, d_sec_lo, d_ds, d_cs;
   logic [6:0]        mm_val, ss_val;
   logic [9:0]        cs_val;
   logic [TIME_W-1:0] stamp_time;
   logic              is_back;

   assign stamp_ok = (stamp_buf_ff[0] == CHAR_OPEN) &&
                     is_digit(stamp_buf_ff[1]) && is_digit(stamp_buf_ff[2]) &&
                     (stamp_buf_ff[3] == CHAR_COLON) &&
                     is_digit(stamp_buf_ff[4]) && is_digit(stamp_buf_ff[5]) &&
                     is_punct(stamp_buf_ff[6]) &&
                     is_digit(stamp_buf_ff[7]) && is_digit(stamp_buf_ff[8]) &&
                     (in_byte_ff == CHAR_CLOSE);

   // ascii digits carry their value in the low nibble
   assign d_min_hi = stamp_buf_ff[1][3:0];
   assign d_min_lo = stamp_buf_ff[2][3:0];
   assign d_sec_hi = stamp_buf_ff[4][3:0];
   assign d_sec_lo = stamp_buf_ff[5][3:0];
   assign d_ds     = stamp_buf_ff[7][3:0];
   assign d_cs     = stamp_buf_ff[8][3:0];

   assign mm_val = 7'({3'b000, d_min_hi} * 7'd10 + {3'b000, d_min_lo});
   assign ss_val = 7'({3'b000, d_sec_hi} * 7'd10 + {3'b000, d_sec_lo});
   assign cs_val = 10'(32'(d_ds) * MS_PER_DSEC + 32'(d_cs) * MS_PER_CSEC);

   // at most 99:99.99, well inside 23 bits
   assign stamp_time = TIME_W'(32'(mm_val) * MS_PER_MIN + 32'(ss_val) * MS_PER_SEC
                               + 32'(cs_val));
   assign is_back    = stamp_time < last_time_ff;

   always_comb begin
      stamp_idx_in = stamp_idx_ff;
      reading_in   = reading_ff;
      show_in      = show_ff;
      last_time_in = last_time_ff;
      stopped_in   = stopped_ff;
      buf_we       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_CHAR;
      rsp_char_in  = '0;
      rsp_time_in  = '0;
      rsp_delay_in = '0;
      rsp_back_in  = 1'b0;

      if (in_restart_ff) begin
         stamp_idx_in = '0;
         reading_in   = 1'b1;
         show_in      = 1'b0;
         last_time_in = '0;
         stopped_in   = 1'b0;
      end else if (stopped_ff) begin
         // halted until restart
      end else if (in_byte_ff == CHAR_NUL) begin
         stopped_in = 1'b1;
      end else if (reading_ff) begin
         if (in_byte_ff == CHAR_LF) begin
            // short line: start gathering over
            stamp_idx_in = '0;
         end else if (stamp_idx_ff < IDX_W'(STAMP_DEPTH)) begin
            buf_we       = 1'b1;
            stamp_idx_in = stamp_idx_ff + IDX_W'(1);
         end else begin
            // closing byte: check the whole stamp
            reading_in = 1'b0;
            if (!stamp_ok) begin
               show_in = 1'b0;
            end else begin
               stamp_idx_in = '0;
               show_in      = 1'b1;
               last_time_in = stamp_time;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_STAMP;
               rsp_time_in  = stamp_time;
               rsp_delay_in = is_back ? '0 : stamp_time - last_time_ff;
               rsp_back_in  = is_back;
            end
         end
      end else if (in_byte_ff == CHAR_CR) begin
         // dropped
      end else if (in_byte_ff == CHAR_LF) begin
         reading_in   = 1'b1;
         stamp_idx_in = '0;
      end else if (show_ff) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_CHAR;
         rsp_char_in  = in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_idx_ff <= '0;
         reading_ff   <= 1'b1;
         show_ff      <= 1'b0;
         last_time_ff <= '0;
         stopped_ff   <= 1'b0;
      end else if (advance) begin
         stamp_idx_ff <= stamp_idx_in;
         reading_ff   <= reading_in;
         show_ff      <= show_in;
         last_time_ff <= last_time_in;
         stopped_ff   <= stopped_in;
      end
   end

   // stamp bytes, no reset: each entry is written before the check reads it
   always_ff @(posedge clock) begin
      if (advance && buf_we) begin
         stamp_buf_ff[stamp_idx_ff] <= in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_char_ff  <= rsp_char_in;
         rsp_time_ff  <= rsp_time_in;
         rsp_delay_ff <= rsp_delay_in;
         rsp_back_ff  <= rsp_back_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_time_ms   = rsp_time_ff;
   assign rsp_delay_ms  = rsp_delay_ff;
   assign rsp_backwards = rsp_back_ff;

   // a backward stamp never carries a delay
   a_back_no_delay : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_back_ff) |-> (rsp_kind_ff == KIND_STAMP) && (rsp_delay_ff == '0))
      else $error("backward stamp with nonzero delay");

   // character results leave the time fields clear
   a_char_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_CHAR) |->
         (rsp_time_ff == '0) && (rsp_delay_ff == '0) && !rsp_back_ff)
      else $error("character result with time fields set");

   // a shown stamp is the one remembered as last time
   a_last_time : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_STAMP) |-> (last_time_ff == rsp_time_ff))
      else $error("last time does not match shown stamp");

   // a halted parser produces nothing for a plain byte
   a_stopped_quiet : assert property (@(posedge clock) disable iff (reset)
      (advance && stopped_ff && !in_restart_ff) |=> !rsp_valid_ff)
      else $error("result produced while halted");

   // the gather index never passes the closing position
   a_idx_range : assert property (@(posedge clock) disable iff (reset)
      stamp_idx_ff <= IDX_W'(STAMP_DEPTH))
      else $error("stamp index out of range");

endmodule

`default_nettype wire
